/* rtl/itw_pkg.sv */
// shared types, token codes and helper functions for the integer to word tokens unit
`timescale 1ns / 1ps

package itw_pkg;

    localparam int VALUE_W  = 31;
    localparam int WORD_W   = 5;
    localparam int DIGITS   = 10;
    localparam int BIN_W    = 32;
    localparam int SHIFT_W  = DIGITS * 4 + BIN_W;
    localparam int GROUPS   = 4;
    localparam int SLOTS    = 5;
    localparam int TOKENS   = GROUPS * SLOTS;
    localparam int IDX_W    = $clog2(TOKENS);

    localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
    localparam logic [WORD_W-1:0] TOK_TEN      = 5'd10;
    localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
    localparam logic [WORD_W-1:0] TOK_THOUSAND = 5'd29;
    localparam logic [WORD_W-1:0] TOK_MILLION  = 5'd30;
    localparam logic [WORD_W-1:0] TOK_BILLION  = 5'd31;

    typedef logic [DIGITS-1:0][3:0] itw_digits_t;

    typedef struct packed {
        logic [TOKENS-1:0]              mask;
        logic [TOKENS-1:0][WORD_W-1:0]  tok;
    } itw_entry_t;

    // two shift-and-add-3 steps of the binary to bcd conversion
    function automatic logic [SHIFT_W-1:0] dabble2(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] t;
        t = s;
        for (int k = 0; k < 2; k++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (t[BIN_W + d*4 +: 4] >= 4'd5)
                    t[BIN_W + d*4 +: 4] = t[BIN_W + d*4 +: 4] + 4'd3;
            end
            t = {t[SHIFT_W-2:0], 1'b0};
        end
        return t;
    endfunction

    function automatic logic [WORD_W-1:0] scale_tok(input int g);
        logic [WORD_W-1:0] r;
        case (g)
            0:       r = TOK_BILLION;
            1:       r = TOK_MILLION;
            default: r = TOK_THOUSAND;
        endcase
        return r;
    endfunction

    // lays out up to five token slots per group and marks the ones spoken
    function automatic itw_entry_t classify(input itw_digits_t dg);
        itw_entry_t e;
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] o;
        logic       all_zero;
        e = '0;
        all_zero = (dg == '0);
        for (int g = 0; g < GROUPS; g++)
        begin
            if (g == 0)
            begin
                h = 4'd0;
                t = 4'd0;
                o = dg[9];
            end
            else
            begin
                h = dg[11 - 3*g];
                t = dg[10 - 3*g];
                o = dg[9 - 3*g];
            end
            e.tok[g*SLOTS + 0] = {1'b0, h};
            e.tok[g*SLOTS + 1] = TOK_HUNDRED;
            if (t < 4'd2)
                e.tok[g*SLOTS + 2] = (t[0] ? TOK_TEN : TOK_ZERO) + {1'b0, o};
            else
                e.tok[g*SLOTS + 2] = TOK_TENS_BASE + {1'b0, t};
            e.tok[g*SLOTS + 3] = {1'b0, o};
            e.tok[g*SLOTS + 4] = scale_tok(g);
            e.mask[g*SLOTS + 0] = (h != 4'd0);
            e.mask[g*SLOTS + 1] = (h != 4'd0);
            e.mask[g*SLOTS + 2] = (t != 4'd0) || (o != 4'd0)
                                  || ((g == GROUPS - 1) && all_zero);
            e.mask[g*SLOTS + 3] = (t >= 4'd2) && (o != 4'd0);
            e.mask[g*SLOTS + 4] = (g < GROUPS - 1)
                                  && ((h != 4'd0) || (t != 4'd0) || (o != 4'd0));
        end
        return e;
    endfunction

endpackage

/* rtl/itw_value_if.sv */
// input channel carrying one number per word
`timescale 1ns / 1ps

interface itw_value_if;
    logic                       valid;
    logic                       ready;
    logic [itw_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* rtl/itw_word_if.sv */
// output channel carrying one token per word
`timescale 1ns / 1ps

interface itw_word_if;
    logic                       valid;
    logic                       ready;
    logic [itw_pkg::WORD_W-1:0] word;
    logic                       last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

/* rtl/itw_front.sv */
// front end: bcd conversion two bits per cycle and token slot classification
`timescale 1ns / 1ps

module itw_front
(
    input  logic                clk,
    input  logic                rst_n,
    itw_value_if.sink           number,
    output logic                push,
    output itw_pkg::itw_entry_t push_entry,
    input  logic                q_full
);
    import itw_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [3:0]           cnt_reg;
    logic [3:0]           cnt_next;
    logic [SHIFT_W-1:0]   sh_reg;
    logic [SHIFT_W-1:0]   sh_next;
    logic                 accept;

    always_comb
    begin
        push         = busy_reg && done_reg && !q_full;
        number.ready = !busy_reg || push;
        accept       = number.valid && number.ready;
        push_entry   = classify(itw_digits_t'(sh_reg[SHIFT_W-1:BIN_W]));

        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;

        if (accept)
        begin
            sh_next   = dabble2({{(DIGITS*4){1'b0}}, 1'b0, number.value});
            cnt_next  = 4'd1;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (push)
        begin
            busy_next = 1'b0;
            done_next = 1'b0;
        end
        else if (busy_reg && !done_reg)
        begin
            sh_next  = dabble2(sh_reg);
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

/* rtl/itw_queue.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps

module itw_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  itw_pkg::itw_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output itw_pkg::itw_entry_t head,
    output logic                empty
);
    import itw_pkg::*;

    itw_entry_t  mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        empty       = (count_reg == 2'd0);
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* rtl/itw_back.sv */
// back end: walks the marked token slots, one word per cycle unless stalled, into the output register
`timescale 1ns / 1ps

module itw_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  itw_pkg::itw_entry_t head,
    input  logic                empty,
    output logic                pop,
    itw_word_if.source          words
);
    import itw_pkg::*;

    logic                        cur_valid_reg;
    logic                        cur_valid_next;
    itw_entry_t                  cur_reg;
    itw_entry_t                  cur_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [WORD_W-1:0]           out_word_reg;
    logic [WORD_W-1:0]           out_word_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    logic                        can_emit;
    logic                        src_valid;
    itw_entry_t                  src;
    logic [IDX_W-1:0]            idx;
    logic [TOKENS-1:0]           rest;

    always_comb
    begin
        can_emit  = !out_valid_reg || words.ready;
        src_valid = cur_valid_reg || !empty;
        src       = cur_valid_reg ? cur_reg : head;
        pop       = !cur_valid_reg && !empty && can_emit;

        // lowest marked slot
        idx = '0;
        for (int i = TOKENS - 1; i >= 0; i--)
        begin
            if (src.mask[i])
                idx = IDX_W'(i);
        end
        rest      = src.mask;
        rest[idx] = 1'b0;

        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;

        if (can_emit)
        begin
            out_valid_next = src_valid;
            if (src_valid)
            begin
                out_word_next  = src.tok[idx];
                out_last_next  = (rest == '0);
                cur_next.mask  = rest;
                cur_next.tok   = src.tok;
                cur_valid_next = (rest != '0);
            end
        end

        words.valid = out_valid_reg;
        words.word  = out_word_reg;
        words.last  = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* rtl/integer_to_word_tokens_unit.sv */
// integer to word tokens unit: top level
//
// number channel: one 31-bit non-negative value per word.
// words channel: the english spelling of that value, one token per word,
// last set on the final token of each number.
// the front end converts the value to ten decimal digits two bits per cycle,
// and takes a new number only when idle or as the previous one is pushed.
// a two-entry queue holds classified numbers; the back end sends one token
// per cycle through its output register while the receiver is ready, so a
// number of up to 16 tokens never holds up the front end.
// the first token of a number passes the converter, the queue and the output
// register before it is offered; it is taken when the receiver is ready.
// reset empties the converter, the queue and the output register; no
// words are pending afterwards.
// when the receiver stalls the output register holds its word, the back end
// stops, the queue fills and the number channel then drops ready.
`timescale 1ns / 1ps

module integer_to_word_tokens_unit
(
    input  logic       clk,
    input  logic       rst_n,
    itw_value_if.sink  number,
    itw_word_if.source words
);
    import itw_pkg::*;

    logic       push;
    itw_entry_t push_entry;
    logic       q_full;
    logic       pop;
    itw_entry_t head;
    logic       empty;

    itw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .number     (number),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    itw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    itw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .words      (words)
    );

endmodule
